// ===== rtl/zigzag_snapshot_store_unit_macros.svh =====
// assertion macros for the snapshot store top level
// expects clk and rst_n in the scope where a macro is used
`ifndef ZIGZAG_SNAPSHOT_STORE_UNIT_MACROS_SVH
`define ZIGZAG_SNAPSHOT_STORE_UNIT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ZSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition must never hold at a clock edge
`define ZSS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/zss_pkg.sv =====
// shared types and constants of the snapshot store
// used by the controller, the datapath and the top level
`default_nettype none

package zss_pkg;

  localparam int WORD_W     = 32;
  localparam int CNT_W      = 11;
  localparam int IDX_W      = 10;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = 5;

  localparam logic [WORD_W-1:0] FILL_WORD = 32'h5353_5353;
  localparam logic [CNT_W-1:0]  CNT_RESET = 11'd1024;

  // bit positions in the select memory
  localparam int SEL_RS = 0;
  localparam int SEL_WS = 1;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_CKPT  = 2'd2,
    MODE_SNAP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ACCESS,
    ST_COMMIT,
    ST_CK_RD,
    ST_CK_WR,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic div_step;
    logic clr_write;
    logic acc_read;
    logic commit;
    logic ck_read;
    logic ck_write;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic ck_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/zigzag_snapshot_store_unit.sv =====
// top level of the double-copy snapshot store
// depends on zss_pkg, zss_ctrl, zss_dp and the assertion macro header
//
//   channel  signals                                              direction
//   in       in_valid in_stall in_mode in_record_index in_write_data  to block
//   out      out_valid out_stall out_read_data out_reduced_index      from block
//   cfg      cfg_valid cfg_ready cfg_records_in_use                   to block
//
// read, write and snapshot read pass from transfer through the bit-serial modulo unit,
// then a memory read state and a commit state, before the result is loaded
// begin checkpoint reads and rewrites the select memory record by record
// after reset a clearing pass over all NUM_RECORDS records runs before in_stall drops
// a finished result waits in the output register while the next item is taken
`default_nettype none

`include "zigzag_snapshot_store_unit_macros.svh"

module zigzag_snapshot_store_unit #(
  parameter int NUM_RECORDS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [zss_pkg::WORD_W-1:0]  in_record_index,
  input  logic [zss_pkg::WORD_W-1:0]  in_write_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [zss_pkg::WORD_W-1:0]  out_read_data,
  output logic [zss_pkg::IDX_W-1:0]   out_reduced_index,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [zss_pkg::CNT_W-1:0]   cfg_records_in_use
);

  import zss_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  mode_t mode_in;

  assign mode_in   = mode_t'(in_mode);
  assign cfg_ready = 1'b1;

  zss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (mode_in),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  zss_dp #(.NUM_RECORDS(NUM_RECORDS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_records_in_use (cfg_records_in_use),
    .in_mode            (mode_in),
    .in_record_index    (in_record_index),
    .in_write_data      (in_write_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_data      (out_read_data),
    .out_reduced_index  (out_reduced_index)
  );

  // checks
  `ZSS_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !cmd.out_load, "result loaded right after input transfer")
  `ZSS_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid, "loaded result not presented")
  `ZSS_ASSERT_NEVER(a_load_over_busy, cmd.out_load && out_valid && out_stall, "result overwrote a stalled one")

endmodule

`default_nettype wire

// ===== rtl/zss_ram.sv =====
// generic single write port, single read port memory with registered read
// no dependencies
`default_nettype none

module zss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/zss_ctrl.sv =====
// sequencing state machine of the snapshot store
// depends on zss_pkg for state, mode, command and status types
`default_nettype none

module zss_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  zss_pkg::mode_t in_mode,
  output logic           in_stall,
  input  zss_pkg::sts_t  sts,
  output zss_pkg::cmd_t  cmd
);

  import zss_pkg::*;

  state_t                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic                   div_last;

  assign div_last = (bit_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // state and step counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  // divider step count
  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    if (cmd.capture) begin
      bit_cnt_nxt = '0;
    end else if (cmd.div_step) begin
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_mode == MODE_CKPT) ? ST_CK_RD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) state_nxt = ST_ACCESS;
      end
      ST_ACCESS: state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_DONE;
      ST_CK_RD: begin
        state_nxt = sts.ck_done ? ST_DONE : ST_CK_WR;
      end
      ST_CK_WR: state_nxt = ST_CK_RD;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: cmd.clr_write = 1'b1;
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_DIV:    cmd.div_step = 1'b1;
      ST_ACCESS: cmd.acc_read = 1'b1;
      ST_COMMIT: cmd.commit   = 1'b1;
      ST_CK_RD:  cmd.ck_read  = !sts.ck_done;
      ST_CK_WR:  cmd.ck_write = 1'b1;
      ST_DONE:   cmd.out_load = sts.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/zss_dp.sv =====
// datapath: item registers, bit-serial modulo, copy and select memories,
// result register; depends on zss_pkg and zss_ram
`default_nettype none

module zss_dp #(
  parameter int NUM_RECORDS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  zss_pkg::cmd_t               cmd,
  output zss_pkg::sts_t               sts,
  input  logic                        cfg_we,
  input  logic [zss_pkg::CNT_W-1:0]   cfg_records_in_use,
  input  zss_pkg::mode_t              in_mode,
  input  logic [zss_pkg::WORD_W-1:0]  in_record_index,
  input  logic [zss_pkg::WORD_W-1:0]  in_write_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [zss_pkg::WORD_W-1:0]  out_read_data,
  output logic [zss_pkg::IDX_W-1:0]   out_reduced_index
);

  import zss_pkg::*;

  localparam int AW = $clog2(NUM_RECORDS);
  localparam int CW = AW + 1;

  logic [CNT_W-1:0]  cfg_r;
  logic [CNT_W-1:0]  n_eff;
  mode_t             mode_r;
  logic [WORD_W-1:0] raw_r;
  logic [WORD_W-1:0] data_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic [CNT_W-1:0]  rem_nxt;
  logic [CW-1:0]     cnt_r;
  logic [WORD_W-1:0] res_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_data_r;
  logic [IDX_W-1:0]  out_idx_r;

  logic [AW-1:0]     idx;
  logic [AW-1:0]     sweep_addr;
  logic              is_write;

  logic              c0_we, c1_we, sel_we, sel_re;
  logic [WORD_W-1:0] c0_wdata;
  logic [1:0]        sel_wdata;
  logic [AW-1:0]     sel_waddr, sel_raddr, c0_waddr;
  logic [WORD_W-1:0] c0_q, c1_q;
  logic [1:0]        sel_q;

  // record count: clamp to the store depth, zero counts as one
  always_comb begin
    if (32'(cfg_r) > 32'(NUM_RECORDS)) begin
      n_eff = CNT_W'(NUM_RECORDS);
    end else if (cfg_r == '0) begin
      n_eff = CNT_W'(1);
    end else begin
      n_eff = cfg_r;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CNT_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_records_in_use;
    end
  end

  // restoring modulo step, one index bit per cycle
  always_comb begin
    rem_sh   = {rem_r, raw_r[WORD_W-1]};
    rem_diff = rem_sh - {1'b0, n_eff};
    rem_nxt  = (rem_sh >= {1'b0, n_eff}) ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  end

  // item registers and divider state
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      raw_r  <= in_record_index;
      data_r <= in_write_data;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      raw_r <= {raw_r[WORD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  // sweep counter for the clearing pass and checkpoint
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.capture) begin
      cnt_r <= '0;
    end else if (cmd.clr_write || cmd.ck_write) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sts.clr_last = (cnt_r == CW'(NUM_RECORDS - 1));
  assign sts.ck_done  = (cnt_r == CW'(n_eff));

  assign idx        = AW'(rem_r);
  assign sweep_addr = AW'(cnt_r);
  assign is_write   = (mode_r == MODE_WRITE);

  // memory write and read controls
  always_comb begin
    c0_we     = cmd.clr_write || (cmd.commit && is_write && !sel_q[SEL_WS]);
    c1_we     = cmd.commit && is_write && sel_q[SEL_WS];
    c0_wdata  = cmd.clr_write ? FILL_WORD : data_r;
    c0_waddr  = cmd.clr_write ? sweep_addr : idx;
    sel_we    = cmd.clr_write || cmd.ck_write || (cmd.commit && is_write);
    sel_re    = cmd.acc_read || cmd.ck_read;
    sel_raddr = cmd.ck_read ? sweep_addr : idx;
    sel_waddr = (cmd.clr_write || cmd.ck_write) ? sweep_addr : idx;
    sel_wdata = '0;
    if (cmd.clr_write) begin
      sel_wdata[SEL_WS] = 1'b1;
      sel_wdata[SEL_RS] = 1'b0;
    end else if (cmd.ck_write) begin
      sel_wdata[SEL_WS] = !sel_q[SEL_RS];
      sel_wdata[SEL_RS] = sel_q[SEL_RS];
    end else begin
      sel_wdata[SEL_WS] = sel_q[SEL_WS];
      sel_wdata[SEL_RS] = sel_q[SEL_WS];
    end
  end

  zss_ram #(.WIDTH(WORD_W), .DEPTH(NUM_RECORDS)) u_copy0 (
    .clk   (clk),
    .we    (c0_we),
    .waddr (c0_waddr),
    .wdata (c0_wdata),
    .re    (cmd.acc_read),
    .raddr (idx),
    .rdata (c0_q)
  );

  zss_ram #(.WIDTH(WORD_W), .DEPTH(NUM_RECORDS)) u_copy1 (
    .clk   (clk),
    .we    (c1_we),
    .waddr (idx),
    .wdata (data_r),
    .re    (cmd.acc_read),
    .raddr (idx),
    .rdata (c1_q)
  );

  zss_ram #(.WIDTH(2), .DEPTH(NUM_RECORDS)) u_select (
    .clk   (clk),
    .we    (sel_we),
    .waddr (sel_waddr),
    .wdata (sel_wdata),
    .re    (sel_re),
    .raddr (sel_raddr),
    .rdata (sel_q)
  );

  // result word, zero unless a read or snapshot read picks a copy
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_r <= '0;
    end else if (cmd.commit) begin
      case (mode_r)
        MODE_READ: res_r <= sel_q[SEL_RS] ? c1_q : c0_q;
        MODE_SNAP: res_r <= sel_q[SEL_WS] ? c0_q : c1_q;
        default:   res_r <= '0;
      endcase
    end
  end

  // output register
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res_r;
      out_idx_r  <= (mode_r == MODE_CKPT) ? '0 : rem_r[IDX_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_data_r;
  assign out_reduced_index = out_idx_r;

endmodule

`default_nettype wire

// ===== dv/zigzag_snapshot_store_unit_tb.sv =====
// self-checking testbench for zigzag_snapshot_store_unit, double-copy record store
// depends on zss_pkg and the rtl top level; holds its own model of records and select bits
`default_nettype none

// tracks the record copies and select bits, predicts one result per input transfer
class record_store_checker;
  localparam int DEPTH = 1024;

  typedef struct {
    bit [zss_pkg::WORD_W-1:0] read_data;
    bit [zss_pkg::IDX_W-1:0]  reduced_index;
  } result_t;

  bit [zss_pkg::CNT_W-1:0]  records_in_use;
  bit [zss_pkg::WORD_W-1:0] copy_zero [DEPTH];
  bit [zss_pkg::WORD_W-1:0] copy_one [DEPTH];
  bit                       read_sel [DEPTH];
  bit                       write_sel [DEPTH];
  result_t                  pending_results [$];
  int unsigned              failures;

  function new();
    records_in_use = zss_pkg::CNT_RESET;
    failures = 0;
    foreach (copy_zero[i]) begin
      copy_zero[i] = zss_pkg::FILL_WORD;
      copy_one[i] = '0;
      read_sel[i] = 1'b0;
      write_sel[i] = 1'b1;
    end
  endfunction

  // count is clamped to the depth, zero behaves as one
  function int unsigned eff_count();
    int unsigned n;
    n = records_in_use;
    if (n > DEPTH) n = DEPTH;
    if (n == 0) n = 1;
    return n;
  endfunction

  function void note_transfer(zss_pkg::mode_t mode, bit [31:0] raw, bit [31:0] wdata);
    int unsigned n;
    bit [31:0] idx;
    result_t res;
    n = eff_count();
    idx = raw % n;
    res.read_data = '0;
    case (mode)
      zss_pkg::MODE_READ: begin
        res.read_data = read_sel[idx] ? copy_one[idx] : copy_zero[idx];
      end
      zss_pkg::MODE_WRITE: begin
        if (write_sel[idx]) copy_one[idx] = wdata;
        else copy_zero[idx] = wdata;
        read_sel[idx] = write_sel[idx];
      end
      zss_pkg::MODE_CKPT: begin
        // only records below the count are flipped
        for (int unsigned i = 0; i < n; i++) write_sel[i] = !read_sel[i];
        idx = '0;
      end
      default: begin
        // stable copy is the one not being written
        res.read_data = write_sel[idx] ? copy_zero[idx] : copy_one[idx];
      end
    endcase
    res.reduced_index = idx[zss_pkg::IDX_W-1:0];
    pending_results.push_back(res);
  endfunction

  function void check_result(logic [31:0] rd, logic [9:0] ri);
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result transfer with nothing expected: read_data %h reduced_index %0d", rd, ri);
      failures++;
      return;
    end
    want = pending_results.pop_front();
    if (rd !== want.read_data) begin
      $error("read_data expected %h actual %h", want.read_data, rd);
      failures++;
    end
    if (ri !== want.reduced_index) begin
      $error("reduced_index expected %0d actual %0d", want.reduced_index, ri);
      failures++;
    end
  endfunction
endclass

module zigzag_snapshot_store_unit_tb;
  import zss_pkg::*;

  localparam int NUM_RECORDS = 1024;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_mode;
  logic [WORD_W-1:0]   in_record_index;
  logic [WORD_W-1:0]   in_write_data;
  logic                out_valid;
  logic                out_stall;
  logic [WORD_W-1:0]   out_read_data;
  logic [IDX_W-1:0]    out_reduced_index;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CNT_W-1:0]    cfg_records_in_use;

  int send_idle_pct;
  int stall_idle_pct;

  record_store_checker store = new();

  // record counts per random phase: tiny, zero, above depth, odd, full, just above depth, 64, 1000, 2
  bit [CNT_W-1:0] phase_counts [9] = '{11'd1, 11'd0, 11'd2047, 11'd5, 11'd1024,
                                       11'd1025, 11'd64, 11'd1000, 11'd2};

  zigzag_snapshot_store_unit #(
    .NUM_RECORDS(NUM_RECORDS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_record_index    (in_record_index),
    .in_write_data      (in_write_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_data      (out_read_data),
    .out_reduced_index  (out_reduced_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_records_in_use (cfg_records_in_use)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check each transfer, then decide the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      store.check_result(out_read_data, out_reduced_index);
    end
    out_stall <= ($urandom_range(0, 99) < stall_idle_pct);
  end

  task automatic send_item(mode_t mode, bit [31:0] raw, bit [31:0] wdata);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_record_index <= raw;
    in_write_data <= wdata;
    do @(posedge clk); while (in_stall);
    store.note_transfer(mode, raw, wdata);
  endtask

  // hold the sender until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (store.pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_record_count(bit [CNT_W-1:0] n);
    cfg_valid <= 1'b1;
    cfg_records_in_use <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    store.records_in_use = n;
  endtask

  // mostly a few hot records so writes, checkpoints and snapshots interact
  function automatic bit [31:0] pick_index(int unsigned n);
    int unsigned hot;
    hot = (n < 8) ? n : 8;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return n * $urandom_range(1, 4);
      3: return n - 1 + n * $urandom_range(0, 2);
      4: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, hot - 1) + n * $urandom_range(0, 5);
    endcase
  endfunction

  task automatic run_random_phase(int items);
    int r;
    mode_t mode;
    for (int k = 0; k < items; k++) begin
      if (k == items / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 30) mode = MODE_READ;
      else if (r < 65) mode = MODE_WRITE;
      else if (r < 70) mode = MODE_CKPT;
      else mode = MODE_SNAP;
      send_item(mode, pick_index(store.eff_count()), $urandom);
    end
    drain_results();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= MODE_READ;
    in_record_index <= '0;
    in_write_data <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_records_in_use <= '0;
    send_idle_pct = 28;
    stall_idle_pct = 78;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_record_count(CNT_RESET);

    // directed: fill word, wrap at the count, both copies through two checkpoints
    send_item(MODE_READ,  32'd0,          32'hFFFF_FFFF);
    send_item(MODE_SNAP,  32'd5,          32'h0);
    send_item(MODE_WRITE, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
    send_item(MODE_READ,  32'd1023,       32'h0);
    send_item(MODE_WRITE, 32'd1024,       32'h0);
    send_item(MODE_READ,  32'd0,          32'h0);
    send_item(MODE_CKPT,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
    send_item(MODE_SNAP,  32'd1023,       32'h0);
    send_item(MODE_WRITE, 32'd1023,       32'hA5A5_A5A5);
    send_item(MODE_READ,  32'd1023,       32'h0);
    send_item(MODE_SNAP,  32'd1023,       32'h0);
    send_item(MODE_SNAP,  32'd0,          32'h0);
    send_item(MODE_WRITE, 32'd0,          32'h5A5A_5A5A);
    send_item(MODE_CKPT,  32'd7,          32'h0);
    send_item(MODE_SNAP,  32'd1023,       32'h0);
    send_item(MODE_WRITE, 32'd1023,       32'h1234_5678);
    send_item(MODE_READ,  32'd1023,       32'h0);
    send_item(MODE_SNAP,  32'd1023,       32'h0);
    send_item(MODE_READ,  32'd2047,       32'h0);
    send_item(MODE_SNAP,  32'd3072,       32'h0);
    send_item(MODE_READ,  32'h8000_0000,  32'h0);
    drain_results();

    // receiver-heavy stalling, then sender-heavy idling, then none
    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_idle_pct = 28;
        stall_idle_pct = 78;
      end else if (p < 6) begin
        send_idle_pct = 78;
        stall_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        stall_idle_pct = 0;
      end
      write_record_count(phase_counts[p]);
      run_random_phase(211);
    end

    repeat (40) @(posedge clk);
    if (store.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", store.pending_results.size());
      store.failures++;
    end
    if (store.failures == 0) begin
      $display("zigzag_snapshot_store_unit_tb OK");
    end else begin
      $display("zigzag_snapshot_store_unit_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("zigzag_snapshot_store_unit_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/zss_pkg.sv
rtl/zss_ram.sv
rtl/zss_ctrl.sv
rtl/zss_dp.sv
rtl/zigzag_snapshot_store_unit.sv
dv/zigzag_snapshot_store_unit_tb.sv
